>>> design/vtbc_pkg.sv
// ----------------------------------------------------------------------------
// vtbc_pkg: shared types and constants
// Sequencer states, configuration register indexes and padding bytes of the
// Vigenere and transposition block cipher core.
// ----------------------------------------------------------------------------
`default_nettype none

package vtbc_pkg;

  // Padding bytes: one 'X' then 'Y' up to the end of the block
  localparam logic [7:0] PAD_FIRST = 8'h58;
  localparam logic [7:0] PAD_REST  = 8'h59;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_ROUNDS = 2'd1,
    REG_KEY_LO = 2'd2,
    REG_KEY_HI = 2'd3
  } vtbc_reg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ROUND,
    ST_SCAN,
    ST_XCHK,
    ST_EMIT
  } vtbc_state_e;

endpackage

`default_nettype wire

>>> design/vtbc_in_if.sv
// ----------------------------------------------------------------------------
// vtbc_in_if: input item channel
// Valid/ready channel carrying one message byte with its flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface vtbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output has_byte,
                  output end_of_message, input ready);
  modport sink (input valid, input data_byte, input has_byte,
                input end_of_message, output ready);
endinterface

`default_nettype wire

>>> design/vtbc_out_if.sv
// ----------------------------------------------------------------------------
// vtbc_out_if: result item channel
// Valid/ready channel carrying one processed byte with its flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface vtbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;
  logic       malformed;

  modport source (output valid, output out_byte, output byte_valid,
                  output last, output malformed, input ready);
  modport sink (input valid, input out_byte, input byte_valid,
                input last, input malformed, output ready);
endinterface

`default_nettype wire

>>> design/vtbc_round.sv
// ----------------------------------------------------------------------------
// vtbc_round: one cipher round over a whole block
// Encipher adds the key bytewise then transposes the square; decipher
// transposes then subtracts the key. Reused once per round by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module vtbc_round #(
  parameter int DIM = 4
) (
  input  logic [DIM*DIM-1:0][7:0] block_i,
  input  logic [DIM*DIM-1:0][7:0] key_i,
  input  logic                    decipher_i,
  output logic [DIM*DIM-1:0][7:0] block_o
);

  localparam int BLK = DIM * DIM;

  logic [BLK-1:0][7:0] sum_s;
  logic [BLK-1:0][7:0] enc_s;
  logic [BLK-1:0][7:0] trn_s;
  logic [BLK-1:0][7:0] dec_s;

  // Add key, transpose (encipher); transpose, subtract key (decipher)
  always_comb begin
    for (int i = 0; i < BLK; i++) begin
      sum_s[i] = block_i[i] + key_i[i];
    end
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        enc_s[r*DIM+c] = sum_s[c*DIM+r];
        trn_s[r*DIM+c] = block_i[c*DIM+r];
      end
    end
    for (int i = 0; i < BLK; i++) begin
      dec_s[i] = trn_s[i] - key_i[i];
    end
    block_o = decipher_i ? dec_s : enc_s;
  end

endmodule

`default_nettype wire

>>> design/vigenere_transposition_block_cipher_core.sv
// ----------------------------------------------------------------------------
// vigenere_transposition_block_cipher_core: byte-stream block cipher
// Gathers bytes into DIM*DIM blocks, runs key-add/transpose rounds on a
// shared round unit, pads on encipher and strips padding on decipher.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one item per handshake: a byte, its has_byte flag and an
//   end_of_message flag. out_if carries result items; the last result of a
//   message has last set. Configuration (mode, round count, 128-bit key) is
//   written through cfg_we_i / cfg_idx_i / cfg_data_i while the core is idle.
//   The core takes one item at a time: in_if.ready is high only when the
//   sequencer is idle. A byte that only fills the block is stored. A byte
//   arriving on a full block first runs round_count rounds on the round
//   unit (one whole-block round per cycle), then gives BLK results,
//   one result per cycle through the output register unless the receiver
//   stalls. Decipher at end of message also scans off the padding. A
//   stalled receiver holds the output register and the sequencer waits;
//   no result is lost. Reset empties the block, clears the output valid
//   and loads encipher mode, one round and an all-zero key.
// ----------------------------------------------------------------------------
`default_nettype none

module vigenere_transposition_block_cipher_core #(
  parameter int DIM = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  vtbc_in_if.sink                           in_if,
  vtbc_out_if.source                        out_if,
  input  logic                              cfg_we_i,
  input  logic [vtbc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vtbc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import vtbc_pkg::*;

  localparam int BLK = DIM * DIM;
  localparam int IW  = $clog2(BLK);
  localparam int LW  = $clog2(BLK + 1);

  // Configuration registers
  logic        mode_q;
  logic [7:0]  rounds_q;
  logic [63:0] key_lo_q;
  logic [63:0] key_hi_q;

  // Sequencer and working state
  vtbc_state_e         state_q, state_d;
  logic [7:0]          byte_q, byte_d;
  logic                has_q, has_d;
  logic                end_q, end_d;
  logic [LW-1:0]       fill_q, fill_d;
  logic                final_q, final_d;
  logic                mal_q, mal_d;
  logic [7:0]          rcnt_q, rcnt_d;
  logic [LW-1:0]       len_q, len_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [BLK-1:0][7:0] store_q, store_d;

  // Output register
  logic       ovalid_q, ovalid_d;
  logic [7:0] obyte_q, obyte_d;
  logic       obv_q, obv_d;
  logic       olast_q, olast_d;
  logic       omal_q, omal_d;

  logic [127:0]        key_all;
  logic [BLK-1:0][7:0] key_s;
  logic [BLK-1:0][7:0] round_s;
  logic [IW-1:0]       ptr;
  logic [7:0]          rd_byte;
  logic                out_free;
  logic                emit_end;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      rounds_q <= 8'd1;
      key_lo_q <= '0;
      key_hi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (vtbc_reg_e'(cfg_idx_i))
        REG_MODE:   mode_q   <= cfg_data_i[0];
        REG_ROUNDS: rounds_q <= cfg_data_i[7:0];
        REG_KEY_LO: key_lo_q <= cfg_data_i;
        REG_KEY_HI: key_hi_q <= cfg_data_i;
        default:    mode_q   <= mode_q;
      endcase
    end
  end

  // Slice key bytes for the round unit
  assign key_all = {key_hi_q, key_lo_q};
  always_comb begin
    for (int i = 0; i < BLK; i++) begin
      key_s[i] = key_all[8*i +: 8];
    end
  end

  vtbc_round #(
    .DIM (DIM)
  ) u_round (
    .block_i    (store_q),
    .key_i      (key_s),
    .decipher_i (mode_q),
    .block_o    (round_s)
  );

  // Single read port: padding scan or emission index
  assign ptr = (state_q == ST_SCAN || state_q == ST_XCHK) ?
               IW'(len_q - 1'b1) : idx_q;
  assign rd_byte  = store_q[ptr];
  assign out_free = !ovalid_q || out_if.ready;
  assign emit_end = (LW'(idx_q) == len_q - 1'b1);

  assign in_if.ready = (state_q == ST_IDLE);

  // Next state and datapath control
  always_comb begin
    state_d  = state_q;
    byte_d   = byte_q;
    has_d    = has_q;
    end_d    = end_q;
    fill_d   = fill_q;
    final_d  = final_q;
    mal_d    = mal_q;
    rcnt_d   = rcnt_q;
    len_d    = len_q;
    idx_d    = idx_q;
    store_d  = store_q;
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    obv_d    = obv_q;
    olast_d  = olast_q;
    omal_d   = omal_q;

    // Drop a taken result
    if (ovalid_q && out_if.ready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_if.valid) begin
          byte_d  = in_if.data_byte;
          has_d   = in_if.has_byte;
          end_d   = in_if.end_of_message;
          state_d = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        priority if (has_q && fill_q == LW'(BLK)) begin
          // Flush the full block before storing the new byte
          final_d = 1'b0;
          rcnt_d  = rounds_q;
          state_d = ST_ROUND;
        end else if (has_q) begin
          store_d[fill_q[IW-1:0]] = byte_q;
          fill_d = fill_q + 1'b1;
          has_d  = 1'b0;
        end else if (end_q) begin
          if (!mode_q) begin
            if (fill_q == LW'(BLK)) begin
              final_d = 1'b0;
            end else begin
              // Pad from the fill point to the end of the block
              for (int i = 0; i < BLK; i++) begin
                if (LW'(i) == fill_q) begin
                  store_d[i] = PAD_FIRST;
                end else if (LW'(i) > fill_q) begin
                  store_d[i] = PAD_REST;
                end
              end
              fill_d  = LW'(BLK);
              final_d = 1'b1;
            end
            rcnt_d  = rounds_q;
            state_d = ST_ROUND;
          end else if (fill_q != LW'(BLK)) begin
            // Incomplete block on decipher: one flagged result
            final_d = 1'b1;
            mal_d   = 1'b1;
            len_d   = '0;
            idx_d   = '0;
            state_d = ST_EMIT;
          end else begin
            final_d = 1'b1;
            rcnt_d  = rounds_q;
            state_d = ST_ROUND;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_ROUND: begin
        if (rcnt_q == 8'd0) begin
          len_d   = LW'(BLK);
          idx_d   = '0;
          state_d = (mode_q && final_q) ? ST_SCAN : ST_EMIT;
        end else begin
          store_d = round_s;
          rcnt_d  = rcnt_q - 8'd1;
        end
      end

      ST_SCAN: begin
        // Strip trailing pad bytes, one per cycle
        if (len_q != '0 && rd_byte == PAD_REST) begin
          len_d = len_q - 1'b1;
        end else begin
          state_d = ST_XCHK;
        end
      end

      ST_XCHK: begin
        if (len_q != '0 && rd_byte == PAD_FIRST) begin
          len_d = len_q - 1'b1;
        end
        idx_d   = '0;
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          if (len_q == '0) begin
            obyte_d = 8'd0;
            obv_d   = 1'b0;
            olast_d = 1'b1;
            omal_d  = mal_q;
          end else begin
            obyte_d = rd_byte;
            obv_d   = 1'b1;
            olast_d = final_q && emit_end;
            omal_d  = 1'b0;
          end
          if (len_q == '0 || emit_end) begin
            // Block done: empty it and close the message if final
            fill_d  = '0;
            state_d = ST_DISPATCH;
            if (final_q) begin
              end_d   = 1'b0;
              final_d = 1'b0;
              mal_d   = 1'b0;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      has_q    <= 1'b0;
      end_q    <= 1'b0;
      fill_q   <= '0;
      final_q  <= 1'b0;
      mal_q    <= 1'b0;
      rcnt_q   <= '0;
      len_q    <= '0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      has_q    <= has_d;
      end_q    <= end_d;
      fill_q   <= fill_d;
      final_q  <= final_d;
      mal_q    <= mal_d;
      rcnt_q   <= rcnt_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Hold payload: pending byte, block store, output fields
  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    store_q <= store_d;
    obyte_q <= obyte_d;
    obv_q   <= obv_d;
    olast_q <= olast_d;
    omal_q  <= omal_d;
  end

  assign out_if.valid      = ovalid_q;
  assign out_if.out_byte   = obyte_q;
  assign out_if.byte_valid = obv_q;
  assign out_if.last       = olast_q;
  assign out_if.malformed  = omal_q;

endmodule

`default_nettype wire

>>> design/vtbc_checker.sv
// ----------------------------------------------------------------------------
// vtbc_checker: port-level checks for the cipher core
// Watches the item channels over time and flags result flag combinations
// the core must never produce.
// ----------------------------------------------------------------------------
`default_nettype none

module vtbc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_byte_valid_i,
  input logic out_last_i,
  input logic out_malformed_i
);

  // A waiting result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  // An accepted item keeps the core busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after an accepted item");

  // A malformed result is a lone closing marker
  a_malformed_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_malformed_i |-> out_last_i && !out_byte_valid_i)
    else $error("malformed result not a closing marker");

  // A result without a byte only closes a message
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_byte_valid_i |-> out_last_i)
    else $error("empty result that does not close a message");

endmodule

bind vigenere_transposition_block_cipher_core vtbc_checker u_vtbc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_if.valid),
  .in_ready_i       (in_if.ready),
  .out_valid_i      (out_if.valid),
  .out_ready_i      (out_if.ready),
  .out_byte_valid_i (out_if.byte_valid),
  .out_last_i       (out_if.last),
  .out_malformed_i  (out_if.malformed)
);

`default_nettype wire
